// ----- sv/ffa_pkg.sv -----
package ffa_pkg;

  localparam int unsigned ArenaMaxBytes = 131072;
  localparam int unsigned AlignBytes    = 4;
  localparam int unsigned HeaderBytes   = 8;

  // width of internal offset and size arithmetic
  localparam int unsigned SzW = 34;

  localparam int unsigned OffW  = 17;
  localparam int unsigned SizeW = 18;
  localparam int unsigned PaddrW = 3;

  localparam logic [PaddrW-1:0] RegArenaBytes = 3'd0;
  localparam logic [SizeW-1:0]  ArenaReset    = 18'd131072;

  typedef enum logic [1:0] {
    REQ_ALLOC   = 2'd0,
    REQ_FREE    = 2'd1,
    REQ_REALLOC = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             has_block;
    logic [OffW-1:0]  block_offset;
    logic [SizeW-1:0] req_size;
  } in_t;

  typedef struct packed {
    logic             status;
    logic             has_result;
    logic [OffW-1:0]  result_offset;
    logic [OffW-1:0]  move_from_offset;
    logic [SizeW-1:0] move_bytes;
  } out_t;

  typedef enum logic [4:0] {
    ST_CLR,
    ST_IDLE,
    ST_DONE,
    ST_F_WR_MARK,
    ST_F_RD_H,
    ST_F_CHK_H,
    ST_F_CHK_N,
    ST_F_CHK_NM,
    ST_A_RD,
    ST_A_HS,
    ST_A_CHK,
    ST_A_SPLIT_RM,
    ST_A_SPLIT_P,
    ST_A_MARK,
    ST_R_RD,
    ST_R_HS,
    ST_R_NS,
    ST_R_NM,
    ST_R_SPLIT_RM,
    ST_R_SPLIT_H,
    ST_R_OLD_RD
  } state_e;

endpackage

// ----- sv/ffa_ram.sv -----
module ffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ----- sv/ffa_cfg.sv -----
module ffa_cfg import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [SizeW-1:0]  arena_bytes_o
);

  logic [SizeW-1:0] arena_q;
  logic             sel_arena;

  // only bit 2 selects the register
  assign sel_arena = (paddr[2] == RegArenaBytes[2]);
  assign pready    = 1'b1;
  assign prdata    = sel_arena ? {{(32-SizeW){1'b0}}, arena_q} : 32'd0;
  assign arena_bytes_o = arena_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ArenaReset;
    end else if (psel && penable && pwrite && pready && sel_arena) begin
      arena_q <= pwdata[SizeW-1:0];
    end
  end

endmodule

// ----- sv/first_fit_arena_allocator.sv -----
// channel   dir  handshake                    payload
// in        in   in_valid_i / in_stall_o      in_i  (in_t: request word)
// out       out  out_valid_o / out_stall_i    out_o (out_t: result word)
// cfg       in   apb psel/penable/pwrite      arena_bytes at address 0
//
// alloc reads the size and mark of each block header visited on the walk (one header
// memory port, registered read), then writes any split remainder, the size and the mark;
// a moving realloc first probes the old block and its successor, then walks, rereads
// the old size and frees the old block
// after reset a clearing pass writes zero to all ARENA_MAX_BYTES/4 header words,
// one word a cycle; no request is taken meanwhile
// one request at a time; the next is taken as soon as the sequencer is idle,
// while the previous result word may still wait in the output register
// out_stall_i only holds a finished result; it never stalls the walk itself
module first_fit_arena_allocator import ffa_pkg::*; #(
  parameter int unsigned ARENA_MAX_BYTES = ArenaMaxBytes,
  parameter int unsigned ALIGN_BYTES     = AlignBytes,
  parameter int unsigned HEADER_BYTES    = HeaderBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_t               in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_t              out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned HDR   = ((HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam int unsigned WORDS = ARENA_MAX_BYTES / 4;
  localparam int unsigned IW    = $clog2(WORDS);

  localparam logic [SzW-1:0] HdrW   = SzW'(HDR);
  localparam logic [SzW-1:0] AlignW = SzW'(ALIGN_BYTES);
  localparam logic [SzW-1:0] MaxW   = SzW'(ARENA_MAX_BYTES);
  localparam logic [SzW-1:0] WordsW = SzW'(WORDS);

  logic [SizeW-1:0] arena_bytes;

  ffa_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .arena_bytes_o (arena_bytes)
  );

  state_e st_q, st_d;

  // working registers of the sequencer
  logic [SzW-1:0] off_q, off_d;    // data offset of the named block
  logic [SzW-1:0] ns_q, ns_d;      // rounded request size
  logic [SzW-1:0] end_q, end_d;    // arena end for this request
  logic [SzW-1:0] p_q, p_d;        // walk pointer / next header
  logic [31:0]    hs_q, hs_d;      // size word of header under test
  logic [31:0]    nxs_q, nxs_d;    // size word of following header
  logic [31:0]    hold_q, hold_d;  // old block size on realloc
  logic           mv_q, mv_d;      // alloc belongs to a moving realloc
  out_t           res_q, res_d;
  logic [IW-1:0]  clr_q, clr_d;

  out_t out_q;
  logic ov_q;

  // header memory access
  logic [SzW-1:0] mem_off;
  logic           mem_we;
  logic [31:0]    mem_wd;
  logic           in_rng, rd_rng_q;
  logic [IW-1:0]  ram_addr;
  logic           ram_we;
  logic [31:0]    ram_wd;
  logic [31:0]    ram_q;
  logic [31:0]    rdat;

  assign in_rng   = (mem_off >> 2) < WordsW;
  assign ram_addr = (st_q == ST_CLR) ? clr_q : mem_off[IW+1:2];
  assign ram_we   = (st_q == ST_CLR) ? 1'b1 : (mem_we && in_rng);
  assign ram_wd   = (st_q == ST_CLR) ? 32'd0 : mem_wd;
  // words past the store read as zero
  assign rdat     = rd_rng_q ? ram_q : 32'd0;

  ffa_ram #(
    .WIDTH (32),
    .DEPTH (WORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wd),
    .rdata_o (ram_q)
  );

  // request decode helpers, valid while idle
  logic [SzW-1:0] in_off, in_req, in_end, in_ns, in_arena;
  logic           in_has;
  logic           accept;

  assign in_arena = SzW'(arena_bytes);
  assign in_end   = ((in_arena > MaxW) ? MaxW : in_arena) & ~SzW'(3);
  assign in_off   = SzW'(in_i.block_offset);
  assign in_req   = SzW'(in_i.req_size);
  assign in_ns    = (in_req == '0) ? AlignW :
                    ((in_req + AlignW - SzW'(1)) / ALIGN_BYTES) * AlignW;
  assign in_has   = in_i.has_block && (in_off >= HdrW) && (in_off[1:0] == 2'b00) &&
                    (in_off <= in_end);

  assign in_stall_o = (st_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // shared sums
  logic [SzW-1:0] hs_w, nxs_w, rd_w, comb_w, h_off;
  assign hs_w   = SzW'(hs_q);
  assign nxs_w  = SzW'(nxs_q);
  assign rd_w   = SzW'(rdat);
  assign comb_w = SzW'(hold_q) + HdrW + nxs_w;
  assign h_off  = off_q - HdrW;

  always_comb begin
    st_d    = st_q;
    off_d   = off_q;
    ns_d    = ns_q;
    end_d   = end_q;
    p_d     = p_q;
    hs_d    = hs_q;
    nxs_d   = nxs_q;
    hold_d  = hold_q;
    mv_d    = mv_q;
    res_d   = res_q;
    clr_d   = clr_q;
    mem_off = '0;
    mem_we  = 1'b0;
    mem_wd  = 32'd0;

    unique case (st_q)
      ST_CLR: begin
        clr_d = clr_q + IW'(1);
        if (clr_q == IW'(WORDS - 1)) begin
          st_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          off_d = in_off;
          ns_d  = in_ns;
          end_d = in_end;
          mv_d  = 1'b0;
          p_d   = '0;
          res_d = '0;
          if (in_i.req_type == REQ_FREE) begin
            st_d = in_has ? ST_F_WR_MARK : ST_DONE;
          end else if (in_i.req_type == REQ_REALLOC && in_has) begin
            if (in_req == '0) begin
              st_d = ST_F_WR_MARK;
            end else if (in_req > MaxW) begin
              res_d.status = 1'b1;
              st_d = ST_DONE;
            end else begin
              st_d = ST_R_RD;
            end
          end else if (in_req > MaxW) begin
            res_d.status = 1'b1;
            st_d = ST_DONE;
          end else begin
            st_d = ST_A_RD;
          end
        end
      end

      // free: clear mark, then merge a free successor
      ST_F_WR_MARK: begin
        // old size as it stands after the new block was taken
        if (mv_q) begin
          res_d.move_bytes = rdat[SizeW-1:0];
        end
        mem_off = h_off + SzW'(4);
        mem_we  = 1'b1;
        st_d    = ST_F_RD_H;
      end
      ST_F_RD_H: begin
        mem_off = h_off;
        st_d    = ST_F_CHK_H;
      end
      ST_F_CHK_H: begin
        hs_d = rdat;
        p_d  = off_q + rd_w;
        if (off_q + rd_w + HdrW <= end_q) begin
          mem_off = off_q + rd_w;
          st_d    = ST_F_CHK_N;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_F_CHK_N: begin
        nxs_d = rdat;
        if (rdat != 32'd0) begin
          mem_off = p_q + SzW'(4);
          st_d    = ST_F_CHK_NM;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_F_CHK_NM: begin
        if (rdat == 32'd0) begin
          mem_off = h_off;
          mem_we  = 1'b1;
          mem_wd  = 32'(hs_w + HdrW + nxs_w);
        end
        st_d = ST_DONE;
      end

      // alloc: first-fit walk of the header chain
      ST_A_RD: begin
        if (p_q + HdrW > end_q) begin
          res_d = '0;
          res_d.status = 1'b1;
          st_d = ST_DONE;
        end else begin
          mem_off = p_q;
          st_d    = ST_A_HS;
        end
      end
      ST_A_HS: begin
        hs_d = rdat;
        if (rdat == 32'd0) begin
          if (p_q + HdrW + ns_q > end_q) begin
            res_d = '0;
            res_d.status = 1'b1;
            st_d = ST_DONE;
          end else begin
            // extend into the never-used tail
            mem_off = p_q;
            mem_we  = 1'b1;
            mem_wd  = 32'(ns_q);
            st_d    = ST_A_MARK;
          end
        end else begin
          mem_off = p_q + SzW'(4);
          st_d    = ST_A_CHK;
        end
      end
      ST_A_CHK: begin
        if (rdat == 32'd0 && hs_w >= ns_q) begin
          if (hs_w >= ns_q + HdrW + AlignW) begin
            // split off the remainder as a free block
            mem_off = p_q + HdrW + ns_q;
            mem_we  = 1'b1;
            mem_wd  = 32'(hs_w - ns_q - HdrW);
            st_d    = ST_A_SPLIT_RM;
          end else begin
            st_d = ST_A_MARK;
          end
        end else begin
          p_d  = p_q + HdrW + hs_w;
          st_d = ST_A_RD;
        end
      end
      ST_A_SPLIT_RM: begin
        mem_off = p_q + HdrW + ns_q + SzW'(4);
        mem_we  = 1'b1;
        st_d    = ST_A_SPLIT_P;
      end
      ST_A_SPLIT_P: begin
        mem_off = p_q;
        mem_we  = 1'b1;
        mem_wd  = 32'(ns_q);
        st_d    = ST_A_MARK;
      end
      ST_A_MARK: begin
        mem_off = p_q + SzW'(4);
        mem_we  = 1'b1;
        mem_wd  = 32'd1;
        res_d.has_result    = 1'b1;
        res_d.result_offset = OffW'(p_q + HdrW);
        if (mv_q) begin
          // moving realloc: report the copy, then free the old block
          res_d.move_from_offset = OffW'(off_q);
          st_d = ST_R_OLD_RD;
        end else begin
          st_d = ST_DONE;
        end
      end
      ST_R_OLD_RD: begin
        // reread the old size, the walk may have rewritten it
        mem_off = h_off;
        st_d    = ST_F_WR_MARK;
      end

      // realloc: try to grow in place
      ST_R_RD: begin
        mem_off = h_off;
        st_d    = ST_R_HS;
      end
      ST_R_HS: begin
        hold_d = rdat;
        p_d    = off_q + rd_w;
        if (rd_w >= ns_q) begin
          res_d.has_result    = 1'b1;
          res_d.result_offset = OffW'(off_q);
          st_d = ST_DONE;
        end else if (off_q + rd_w + HdrW <= end_q) begin
          mem_off = off_q + rd_w;
          st_d    = ST_R_NS;
        end else begin
          mv_d = 1'b1;
          p_d  = '0;
          st_d = ST_A_RD;
        end
      end
      ST_R_NS: begin
        nxs_d = rdat;
        if (rdat != 32'd0) begin
          mem_off = p_q + SzW'(4);
          st_d    = ST_R_NM;
        end else if (off_q + ns_q <= end_q) begin
          mem_off = h_off;
          mem_we  = 1'b1;
          mem_wd  = 32'(ns_q);
          res_d.has_result    = 1'b1;
          res_d.result_offset = OffW'(off_q);
          st_d = ST_DONE;
        end else begin
          mv_d = 1'b1;
          p_d  = '0;
          st_d = ST_A_RD;
        end
      end
      ST_R_NM: begin
        if (rdat == 32'd0 && comb_w >= ns_q) begin
          if (comb_w >= ns_q + HdrW + AlignW) begin
            mem_off = off_q + ns_q;
            mem_we  = 1'b1;
            mem_wd  = 32'(comb_w - ns_q - HdrW);
            st_d    = ST_R_SPLIT_RM;
          end else begin
            mem_off = h_off;
            mem_we  = 1'b1;
            mem_wd  = 32'(comb_w);
            res_d.has_result    = 1'b1;
            res_d.result_offset = OffW'(off_q);
            st_d = ST_DONE;
          end
        end else begin
          mv_d = 1'b1;
          p_d  = '0;
          st_d = ST_A_RD;
        end
      end
      ST_R_SPLIT_RM: begin
        mem_off = off_q + ns_q + SzW'(4);
        mem_we  = 1'b1;
        st_d    = ST_R_SPLIT_H;
      end
      ST_R_SPLIT_H: begin
        mem_off = h_off;
        mem_we  = 1'b1;
        mem_wd  = 32'(ns_q);
        res_d.has_result    = 1'b1;
        res_d.result_offset = OffW'(off_q);
        st_d = ST_DONE;
      end

      ST_DONE: begin
        // wait for the output register to be free
        if (!ov_q || !out_stall_i) begin
          st_d = ST_IDLE;
        end
      end

      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ST_CLR;
      clr_q <= '0;
      ov_q  <= 1'b0;
      mv_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      mv_q  <= mv_d;
      if (st_q == ST_DONE && (!ov_q || !out_stall_i)) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    ns_q     <= ns_d;
    end_q    <= end_d;
    p_q      <= p_d;
    hs_q     <= hs_d;
    nxs_q    <= nxs_d;
    hold_q   <= hold_d;
    res_q    <= res_d;
    rd_rng_q <= in_rng;
    if (st_q == ST_DONE && (!ov_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  // no request is taken during the clearing pass
  ast_clr_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLR |-> in_stall_o)
    else $error("request taken during header clear");

  // a failed request reports no block and no moved bytes
  ast_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status) |-> (!out_o.has_result && out_o.move_bytes == '0))
    else $error("out of memory result carries a block");

  // a finished result waits while the output is held
  ast_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && ov_q && out_stall_i) |=> st_q == ST_DONE)
    else $error("result dropped while output stalled");

  // clearing writes only zero words
  ast_clr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_CLR |-> (ram_we && ram_wd == 32'd0))
    else $error("clear pass wrote nonzero");

endmodule

// ----- test/first_fit_arena_allocator_checker.sv -----
`timescale 1ns / 100ps

module first_fit_arena_allocator_checker import ffa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_t               in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_t              out_word_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [PaddrW-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint unsigned Hdr =
      ((HeaderBytes + AlignBytes - 1) / AlignBytes) * AlignBytes;
  localparam longint unsigned StoreWords = ArenaMaxBytes / 4;

  logic [31:0]      header_mem [StoreWords];
  logic [SizeW-1:0] arena_size;
  out_t             expected_words [$];

  function automatic longint unsigned hdr_read(longint unsigned o);
    longint unsigned i;
    i = o >> 2;
    return (i < StoreWords) ? 64'(header_mem[i]) : 64'd0;
  endfunction

  function automatic void hdr_write(longint unsigned o, longint unsigned v);
    longint unsigned i;
    i = o >> 2;
    if (i < StoreWords) header_mem[i] = v[31:0];
  endfunction

  function automatic longint unsigned arena_limit();
    longint unsigned e;
    e = arena_size;
    if (e > ArenaMaxBytes) e = ArenaMaxBytes;
    return e & ~64'd3;
  endfunction

  function automatic longint unsigned round_up(longint unsigned s);
    if (s == 0) s = 1;
    return ((s + AlignBytes - 1) / AlignBytes) * AlignBytes;
  endfunction

  // first-fit walk; store untouched when nothing fits
  function automatic bit first_fit(longint unsigned size, output longint unsigned data);
    longint unsigned lim, p, hs, r;
    lim = arena_limit();
    p = 0;
    data = 0;
    while (p + Hdr <= lim) begin
      hs = hdr_read(p);
      if (hs == 0) begin
        if (p + Hdr + size > lim) return 0;
        hdr_write(p, size);
        hdr_write(p + 4, 1);
        data = p + Hdr;
        return 1;
      end
      if (hdr_read(p + 4) == 0 && hs >= size) begin
        if (hs >= size + Hdr + AlignBytes) begin
          r = p + Hdr + size;
          hdr_write(r, hs - size - Hdr);
          hdr_write(r + 4, 0);
          hdr_write(p, size);
        end
        hdr_write(p + 4, 1);
        data = p + Hdr;
        return 1;
      end
      p += Hdr + hs;
    end
    return 0;
  endfunction

  // clear the mark, merge a free successor
  function automatic void release_block(longint unsigned data);
    longint unsigned h, nxt, ns;
    h = data - Hdr;
    hdr_write(h + 4, 0);
    nxt = data + hdr_read(h);
    if (nxt + Hdr <= arena_limit()) begin
      ns = hdr_read(nxt);
      if (ns > 0 && hdr_read(nxt + 4) == 0) hdr_write(h, hdr_read(h) + Hdr + ns);
    end
  endfunction

  function automatic out_t predict_result(in_t w);
    longint unsigned off, req, lim, ns, h, hs, nxt, nxs, comb, r, data;
    longint unsigned res, mfrom, mbytes;
    bit has, ok, hres, fail;
    out_t o;
    off = w.block_offset;
    req = w.req_size;
    lim = arena_limit();
    has = w.has_block && off >= Hdr && off[1:0] == 2'b00 && off <= lim;
    res = 0; mfrom = 0; mbytes = 0; hres = 0; fail = 0;
    if (w.req_type == REQ_FREE) begin
      if (has) release_block(off);
    end else if (w.req_type == REQ_REALLOC && has) begin
      if (req == 0) begin
        release_block(off);
      end else if (req > ArenaMaxBytes) begin
        fail = 1;
      end else begin
        ns = round_up(req);
        h = off - Hdr;
        hs = hdr_read(h);
        ok = 0;
        if (hs >= ns) begin
          ok = 1;
        end else begin
          nxt = off + hs;
          if (nxt + Hdr <= lim) begin
            nxs = hdr_read(nxt);
            if (nxs > 0 && hdr_read(nxt + 4) == 0) begin
              comb = hs + Hdr + nxs;
              if (comb >= ns) begin
                hdr_write(h, comb);
                if (comb >= ns + Hdr + AlignBytes) begin
                  r = off + ns;
                  hdr_write(r, comb - ns - Hdr);
                  hdr_write(r + 4, 0);
                  hdr_write(h, ns);
                end
                ok = 1;
              end
            end
            // grow into the untouched tail
            if (!ok && nxs == 0 && off + ns <= lim) begin
              hdr_write(h, ns);
              ok = 1;
            end
          end
        end
        if (ok) begin
          hres = 1;
          res = off;
        end else if (first_fit(ns, data)) begin
          hres = 1;
          res = data;
          mfrom = off;
          mbytes = hdr_read(h);
          release_block(off);
        end else begin
          fail = 1;
        end
      end
    end else begin
      if (req > ArenaMaxBytes) fail = 1;
      else if (first_fit(round_up(req), data)) begin
        hres = 1;
        res = data;
      end else fail = 1;
    end
    o.status           = fail;
    o.has_result       = hres;
    o.result_offset    = res[OffW-1:0];
    o.move_from_offset = mfrom[OffW-1:0];
    o.move_bytes       = mbytes[SizeW-1:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t e;
    if (!rst_ni) begin
      for (int i = 0; i < StoreWords; i++) header_mem[i] = '0;
      arena_size = ArenaReset;
      expected_words.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results first: one leaving now belongs to an older request
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with no request waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_words.pop_front();
          if (out_word_i != e) fail_count_o <= fail_count_o + 1;
          if (out_word_i.status != e.status)
            $error("status exp %0d act %0d", e.status, out_word_i.status);
          if (out_word_i.has_result != e.has_result)
            $error("has_result exp %0d act %0d", e.has_result, out_word_i.has_result);
          if (out_word_i.result_offset != e.result_offset)
            $error("result_offset exp %0d act %0d", e.result_offset,
                   out_word_i.result_offset);
          if (out_word_i.move_from_offset != e.move_from_offset)
            $error("move_from_offset exp %0d act %0d", e.move_from_offset,
                   out_word_i.move_from_offset);
          if (out_word_i.move_bytes != e.move_bytes)
            $error("move_bytes exp %0d act %0d", e.move_bytes, out_word_i.move_bytes);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == RegArenaBytes)
        arena_size = pwdata_i[SizeW-1:0];
      if (in_valid_i && !in_stall_i) expected_words.push_back(predict_result(in_word_i));
      pending_o <= expected_words.size();
    end
  end

endmodule

// ----- test/first_fit_arena_allocator_test.sv -----
`timescale 1ns / 100ps

module first_fit_arena_allocator_test;
  import ffa_pkg::*;

  localparam int          CycleLimit = 6000000;
  localparam int          WordsPerPhase = 330;
  localparam int          LiveCap = 24;
  // request code the block takes as alloc
  localparam logic [1:0]  ReqSpare = 2'd3;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  in_t               in_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  out_t              out_o;
  logic              psel = 0;
  logic              penable = 0;
  logic              pwrite = 0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int                fail_count;
  int                pending;
  int                cycles = 0;
  int                stall_left = 0;
  bit                steady = 0;       // no idling on either side while set
  logic [OffW-1:0]   live_blocks [$];  // data offsets currently handed out

  always #2 clk_i = ~clk_i;

  first_fit_arena_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_i, .out_valid_o, .out_stall_i,
    .out_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  first_fit_arena_allocator_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_word_i(in_i),
    .out_valid_i(out_valid_o), .out_stall_i, .out_word_i(out_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("first_fit_arena_allocator test failed");
      $finish;
    end
  end

  // receiver: after each accepted result word, stall at random (never while steady);
  // also remember which blocks are handed out so frees hit real blocks
  always @(posedge clk_i or negedge rst_ni) begin
    int n;
    if (!rst_ni) begin
      out_stall_i <= 0;
      stall_left <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      n = steady ? 0 : $urandom_range(0, 3);
      stall_left <= n;
      out_stall_i <= (n != 0);
      if (out_o.has_result && out_o.move_bytes == 0 && out_o.move_from_offset == 0) begin
        // in-place realloc hands back an offset already dropped by the sender
        live_blocks.push_back(out_o.result_offset);
      end else if (out_o.has_result) begin
        live_blocks.push_back(out_o.result_offset);
      end
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end
  end

  function automatic in_t make_word(logic [1:0] kind, logic has, int unsigned off,
                                    int unsigned size);
    in_t w;
    w.req_type     = kind;
    w.has_block    = has;
    w.block_offset = off[OffW-1:0];
    w.req_size     = size[SizeW-1:0];
    return w;
  endfunction

  // valid stays high between back-to-back words, so it is only lowered for a gap
  task automatic send_word(in_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0 || out_valid_o) @(posedge clk_i);
  endtask

  task automatic write_arena(int unsigned bytes);
    psel <= 1;
    pwrite <= 1;
    paddr <= RegArenaBytes;
    pwdata <= bytes;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  function automatic int unsigned draw_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(0, 64);
    if (r < 95) return $urandom_range(65, 1024);
    return $urandom_range(1025, ArenaMaxBytes);
  endfunction

  // pick a live block and forget it; the result brings it back if it survives
  function automatic int unsigned take_live();
    int idx;
    logic [OffW-1:0] off;
    idx = $urandom_range(0, live_blocks.size() - 1);
    off = live_blocks[idx];
    live_blocks.delete(idx);
    return off;
  endfunction

  task automatic random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // noise: any field value, unused request code included
      send_word(make_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                          $urandom_range(0, 131071), $urandom_range(0, 262143)));
    end else if (live_blocks.size() == 0 || (pick < 45 && live_blocks.size() < LiveCap)) begin
      send_word(make_word(REQ_ALLOC, 1'($urandom_range(0, 1)), $urandom_range(0, 131071),
                          draw_size()));
    end else if (pick < 75 || live_blocks.size() >= LiveCap) begin
      send_word(make_word(REQ_FREE, 1, take_live(), $urandom_range(0, 262143)));
    end else begin
      send_word(make_word(REQ_REALLOC, 1, take_live(),
                          ($urandom_range(0, 9) == 0) ? 0 : draw_size()));
    end
  endtask

  initial begin
    int unsigned arena_steps [6] = '{131072, 16, 262143, 4096, 128, 1000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;

    // directed: size extremes, every request kind, null and malformed offsets
    send_word(make_word(REQ_ALLOC, 0, 0, 0));
    send_word(make_word(REQ_ALLOC, 0, 0, 1));
    send_word(make_word(REQ_ALLOC, 0, 0, 40));
    send_word(make_word(REQ_REALLOC, 1, 8, 100));           // moving realloc
    send_word(make_word(REQ_REALLOC, 1, 20, 4));            // fits already
    send_word(make_word(REQ_REALLOC, 1, 132, 300));         // grows into tail
    send_word(make_word(REQ_ALLOC, 0, 0, 4));               // reuses freed block
    send_word(make_word(REQ_FREE, 1, 20, 0));
    send_word(make_word(REQ_REALLOC, 1, 8, 8));             // grows into freed next
    send_word(make_word(REQ_REALLOC, 1, 8, 0));             // realloc to zero frees
    send_word(make_word(REQ_REALLOC, 0, 0, 16));            // null realloc allocates
    send_word(make_word(REQ_REALLOC, 1, 28, ArenaMaxBytes + 1));
    send_word(make_word(REQ_ALLOC, 0, 0, ArenaMaxBytes + 1));
    send_word(make_word(REQ_ALLOC, 0, 0, 262143));
    send_word(make_word(REQ_ALLOC, 0, 0, ArenaMaxBytes));   // too big with headers
    send_word(make_word(REQ_FREE, 0, 8, 0));                // null free
    send_word(make_word(REQ_FREE, 1, 4, 0));                // below header
    send_word(make_word(REQ_FREE, 1, 30, 0));               // misaligned
    send_word(make_word(REQ_FREE, 1, 131071, 0));
    send_word(make_word(ReqSpare, 1, 131068, 12));
    send_word(make_word(REQ_ALLOC, 1, 131068, 0));
    wait_drained();

    foreach (arena_steps[i]) begin
      write_arena(arena_steps[i]);
      steady = (i % 3 == 2);
      for (int k = 0; k < WordsPerPhase; k++) random_word();
      wait_drained();
    end

    // quiet period in case a stray word turns up
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("first_fit_arena_allocator test passed");
    else
      $display("first_fit_arena_allocator test failed");
    $finish;
  end

endmodule

// ----- first_fit_arena_allocator.f -----
sv/ffa_pkg.sv
sv/ffa_ram.sv
sv/ffa_cfg.sv
sv/first_fit_arena_allocator.sv
test/first_fit_arena_allocator_checker.sv
test/first_fit_arena_allocator_test.sv
